>>> hw/rtl/plwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwm_pkg
// Shared types and constants of the piecewise-linear time map unit.
// ----------------------------------------------------------------------------
package plwm_pkg;

    localparam int TIME_BITS = 32;
    localparam int PROD_BITS = 2 * TIME_BITS;
    localparam int DCNT_W    = $clog2(PROD_BITS + 1);
    localparam int IDX_W     = 6;
    localparam int COUNT_W   = 7;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_FWD   = 2'd1;
    localparam logic [1:0] FUNC_INV   = 2'd2;
    localparam logic [1:0] FUNC_RANGE = 2'd3;

    typedef enum logic [1:0] {
        OP_WRITE = FUNC_WRITE,
        OP_FWD   = FUNC_FWD,
        OP_INV   = FUNC_INV,
        OP_RANGE = FUNC_RANGE
    } t_op;

    typedef struct packed {
        logic [1:0]           func;
        logic [IDX_W-1:0]     entry_index;
        logic [TIME_BITS-1:0] time_a;
        logic [TIME_BITS-1:0] time_b;
    } t_in_beat;

    typedef struct packed {
        logic [TIME_BITS-1:0] mapped_time;
        logic                 is_identity;
    } t_out_beat;

    // Classified command handed from the front end to the back end.
    typedef struct packed {
        t_op                  op;
        logic                 wr_ok;
        logic [IDX_W-1:0]     entry_index;
        logic [TIME_BITS-1:0] time_a;
        logic [TIME_BITS-1:0] time_b;
    } t_cmd;

endpackage

>>> hw/rtl/piecewise_linear_time_map_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_time_map_unit
// Breakpoint table with forward and inverse piecewise-linear time mapping.
// ----------------------------------------------------------------------------
// Usage: input beats arrive on i_in_valid / o_in_ready carrying a function
// code, a table index and two Q16.16 times. A write beat stores one
// breakpoint and yields no result. Forward and inverse map beats and
// identity range queries each yield one result beat on o_out_valid /
// i_out_ready. The breakpoint count is set through i_cfg_we / i_cfg_wdata
// while the unit is idle.
// A write completes in the execution engine as soon as it is popped. A map
// clamped at a table end skips the search; an interior map runs a binary
// search and then the 64-step serial divider that follows the single
// 32x32 multiply. A range query runs a binary search and then walks the
// breakpoints one at a time. Each table read goes through the registered
// RAM read port.
// One command executes at a time; a two-entry queue behind the input
// register lets new beats be taken while the engine is busy. A stalled
// receiver holds the result in the output register and the engine waits
// on it. Reset clears the count to zero and empties all queues; table
// contents are not cleared.
// ----------------------------------------------------------------------------
module piecewise_linear_time_map_unit #(
    parameter int MAX_HANDLES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  plwm_pkg::t_in_beat           i_in_beat,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output plwm_pkg::t_out_beat          o_out_beat,
    input  logic                         i_cfg_we,
    input  logic [plwm_pkg::COUNT_W-1:0] i_cfg_wdata
);

    // Number of live breakpoints; values above the table depth are
    // clamped inside the engine.
    logic [plwm_pkg::COUNT_W-1:0] r_handle_count;

    logic           w_push;
    logic           w_full;
    logic           w_pop;
    logic           w_empty;
    plwm_pkg::t_cmd w_front_cmd;
    plwm_pkg::t_cmd w_queue_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_handle_count <= '0;
        end else if (i_cfg_we) begin
            r_handle_count <= i_cfg_wdata;
        end
    end

    // Front end: accepts beats and decodes them into commands.
    plwm_front #(.MAX_HANDLES(MAX_HANDLES)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .o_push     (w_push),
        .o_cmd      (w_front_cmd),
        .i_full     (w_full)
    );

    // Queue decoupling the front end from the execution engine.
    plwm_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_empty (w_empty)
    );

    // Execution engine with the breakpoint RAMs and the output register.
    plwm_back #(.MAX_HANDLES(MAX_HANDLES)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_handle_count (r_handle_count),
        .i_empty        (w_empty),
        .i_cmd          (w_queue_cmd),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_beat     (o_out_beat)
    );

endmodule

>>> hw/rtl/plwm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwm_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module plwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/plwm_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwm_fifo
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module plwm_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  plwm_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output plwm_pkg::t_cmd o_cmd,
    output logic           o_empty
);

    plwm_pkg::t_cmd r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           c_wr;
    logic           c_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign c_wr    = i_push && !o_full;
    assign c_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (c_wr) begin
                r_mem[r_wp] <= i_cmd;
                r_wp        <= ~r_wp;
            end
            if (c_rd) begin
                r_rp <= ~r_rp;
            end
            if (c_wr && !c_rd) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (c_rd && !c_wr) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

>>> hw/rtl/plwm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwm_front
// Accepts input beats, decodes the function and range-checks writes.
// ----------------------------------------------------------------------------
module plwm_front #(
    parameter int MAX_HANDLES = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  plwm_pkg::t_in_beat i_in_beat,
    output logic               o_push,
    output plwm_pkg::t_cmd     o_cmd,
    input  logic               i_full
);

    logic           r_valid;
    plwm_pkg::t_cmd r_cmd;
    plwm_pkg::t_cmd n_cmd;

    always_comb begin
        n_cmd.op          = plwm_pkg::t_op'(i_in_beat.func);
        n_cmd.wr_ok       = (32'(i_in_beat.entry_index) < MAX_HANDLES);
        n_cmd.entry_index = i_in_beat.entry_index;
        n_cmd.time_a      = i_in_beat.time_a;
        n_cmd.time_b      = i_in_beat.time_b;
    end

    assign o_in_ready = !r_valid || !i_full;
    assign o_push     = r_valid;
    assign o_cmd      = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                r_valid <= 1'b1;
                r_cmd   <= n_cmd;
            end else if (!i_full) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

>>> hw/rtl/plwm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plwm_back
// Executes commands: table writes, binary search, interpolation with a
// serial restoring divider, and the identity range walk.
// ----------------------------------------------------------------------------
module plwm_back #(
    parameter int MAX_HANDLES = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [plwm_pkg::COUNT_W-1:0]    i_handle_count,
    input  logic                            i_empty,
    input  plwm_pkg::t_cmd                  i_cmd,
    output logic                            o_pop,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output plwm_pkg::t_out_beat             o_out_beat
);

    localparam int AW = $clog2(MAX_HANDLES);
    localparam int CW = $clog2(MAX_HANDLES + 1);
    localparam int TB = plwm_pkg::TIME_BITS;
    localparam int PB = plwm_pkg::PROD_BITS;
    localparam int DW = plwm_pkg::DCNT_W;

    typedef enum logic [3:0] {
        S_IDLE, S_K0, S_KN, S_SI, S_SC, S_L, S_R, S_MUL, S_DIV, S_FIN,
        S_WI, S_WC, S_OUT
    } t_state;

    t_state              r_state, n_state;
    plwm_pkg::t_cmd      r_cmd, n_cmd;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_step, n_step;
    logic [TB-1:0]       r_vl, n_vl;
    logic [TB-1:0]       r_kl, n_kl;
    logic [TB-1:0]       r_a, n_a;
    logic [TB-1:0]       r_b, n_b;
    logic [TB-1:0]       r_span, n_span;
    logic                r_neg, n_neg;
    logic [PB-1:0]       r_prod, n_prod;
    logic [TB-1:0]       r_rem, n_rem;
    logic [DW-1:0]       r_dcnt, n_dcnt;
    plwm_pkg::t_out_beat r_res, n_res;
    logic                r_out_valid, n_out_valid;
    plwm_pkg::t_out_beat r_out, n_out;

    logic [CW-1:0]       c_n;
    logic [AW-1:0]       c_raddr;
    logic                c_we;
    logic [TB-1:0]       w_src;
    logic [TB-1:0]       w_out;
    logic [TB-1:0]       c_key;
    logic [TB-1:0]       c_val;
    logic [TB:0]         c_rem2;
    logic [CW-1:0]       c_i;
    logic [TB-1:0]       c_x;

    plwm_ram #(.WIDTH(TB), .DEPTH(MAX_HANDLES)) u_src_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (AW'(i_cmd.entry_index)),
        .i_wdata (i_cmd.time_a),
        .i_raddr (c_raddr),
        .o_rdata (w_src)
    );

    plwm_ram #(.WIDTH(TB), .DEPTH(MAX_HANDLES)) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (AW'(i_cmd.entry_index)),
        .i_wdata (i_cmd.time_b),
        .i_raddr (c_raddr),
        .o_rdata (w_out)
    );

    always_comb begin
        if (32'(i_handle_count) > MAX_HANDLES) begin
            c_n = CW'(MAX_HANDLES);
        end else begin
            c_n = CW'(i_handle_count);
        end
    end

    assign o_pop       = (r_state == S_IDLE) && !i_empty;
    assign c_we        = o_pop && (i_cmd.op == plwm_pkg::OP_WRITE) && i_cmd.wr_ok;
    assign c_key       = (r_cmd.op == plwm_pkg::OP_INV) ? w_out : w_src;
    assign c_val       = (r_cmd.op == plwm_pkg::OP_INV) ? w_src : w_out;
    assign c_x         = r_cmd.time_a;
    assign c_rem2      = {r_rem, r_prod[PB-1]};
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_lo     = r_lo;
        n_cnt    = r_cnt;
        n_step   = r_step;
        n_vl     = r_vl;
        n_kl     = r_kl;
        n_a      = r_a;
        n_b      = r_b;
        n_span   = r_span;
        n_neg    = r_neg;
        n_prod   = r_prod;
        n_rem    = r_rem;
        n_dcnt   = r_dcnt;
        n_res    = r_res;
        c_raddr  = '0;
        c_i      = r_lo;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out    = r_out;

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    n_cmd = i_cmd;
                    n_res = '0;
                    unique case (i_cmd.op)
                        plwm_pkg::OP_WRITE: begin
                            n_state = S_IDLE;
                        end
                        plwm_pkg::OP_FWD, plwm_pkg::OP_INV: begin
                            if (c_n < CW'(2)) begin
                                n_res.mapped_time = i_cmd.time_a;
                                n_state = S_OUT;
                            end else begin
                                c_raddr = '0;
                                n_state = S_K0;
                            end
                        end
                        plwm_pkg::OP_RANGE: begin
                            if (c_n == '0 || i_cmd.time_b <= i_cmd.time_a) begin
                                n_res.is_identity = 1'b1;
                                n_state = S_OUT;
                            end else begin
                                n_lo    = '0;
                                n_cnt   = c_n;
                                n_state = S_SI;
                            end
                        end
                    endcase
                end
            end
            S_K0: begin
                if (c_x <= c_key) begin
                    n_res.mapped_time = c_val;
                    n_state = S_OUT;
                end else begin
                    c_raddr = AW'(c_n - CW'(1));
                    n_state = S_KN;
                end
            end
            S_KN: begin
                if (c_x >= c_key) begin
                    n_res.mapped_time = c_val;
                    n_state = S_OUT;
                end else begin
                    n_lo    = '0;
                    n_cnt   = c_n;
                    n_state = S_SI;
                end
            end
            S_SI: begin
                if (r_cnt == '0) begin
                    if (r_cmd.op == plwm_pkg::OP_RANGE) begin
                        n_lo    = (r_lo != '0) ? r_lo - CW'(1) : '0;
                        n_state = S_WI;
                    end else begin
                        if (r_lo < CW'(1)) begin
                            c_i = CW'(1);
                        end else if (r_lo > c_n - CW'(1)) begin
                            c_i = c_n - CW'(1);
                        end else begin
                            c_i = r_lo;
                        end
                        n_lo    = c_i;
                        c_raddr = AW'(c_i - CW'(1));
                        n_state = S_L;
                    end
                end else begin
                    n_step  = r_cnt >> 1;
                    c_raddr = AW'(r_lo + (r_cnt >> 1));
                    n_state = S_SC;
                end
            end
            S_SC: begin
                if (!(c_x < c_key)) begin
                    n_lo  = r_lo + r_step + CW'(1);
                    n_cnt = r_cnt - r_step - CW'(1);
                end else begin
                    n_cnt = r_step;
                end
                n_state = S_SI;
            end
            S_L: begin
                n_kl    = c_key;
                n_vl    = c_val;
                c_raddr = AW'(r_lo);
                n_state = S_R;
            end
            S_R: begin
                if (c_x == r_kl) begin
                    n_res.mapped_time = r_vl;
                    n_state = S_OUT;
                end else if (c_x == c_key) begin
                    n_res.mapped_time = c_val;
                    n_state = S_OUT;
                end else if (c_key <= r_kl) begin
                    n_res.mapped_time = r_vl;
                    n_state = S_OUT;
                end else begin
                    if (c_x >= r_kl) begin
                        n_a   = c_x - r_kl;
                        n_neg = 1'b0;
                    end else begin
                        n_a   = r_kl - c_x;
                        n_neg = 1'b1;
                    end
                    if (c_val >= r_vl) begin
                        n_b = c_val - r_vl;
                    end else begin
                        n_b   = r_vl - c_val;
                        n_neg = ~n_neg;
                    end
                    n_span  = c_key - r_kl;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = PB'(r_a) * PB'(r_b);
                n_rem   = '0;
                n_dcnt  = DW'(PB);
                n_state = S_DIV;
            end
            S_DIV: begin
                if (c_rem2 >= {1'b0, r_span}) begin
                    n_rem  = TB'(c_rem2 - {1'b0, r_span});
                    n_prod = {r_prod[PB-2:0], 1'b1};
                end else begin
                    n_rem  = c_rem2[TB-1:0];
                    n_prod = {r_prod[PB-2:0], 1'b0};
                end
                n_dcnt = r_dcnt - DW'(1);
                if (r_dcnt == DW'(1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_res.mapped_time = r_neg ? r_vl - r_prod[TB-1:0]
                                          : r_vl + r_prod[TB-1:0];
                n_state = S_OUT;
            end
            S_WI: begin
                if (r_lo < c_n) begin
                    c_raddr = AW'(r_lo);
                    n_state = S_WC;
                end else begin
                    n_res.is_identity = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_WC: begin
                if (w_src <= r_cmd.time_b) begin
                    if (w_out != w_src) begin
                        n_res.is_identity = 1'b0;
                        n_state = S_OUT;
                    end else begin
                        n_lo    = r_lo + CW'(1);
                        n_state = S_WI;
                    end
                end else begin
                    n_res.is_identity = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cmd       <= n_cmd;
            r_lo        <= n_lo;
            r_cnt       <= n_cnt;
            r_step      <= n_step;
            r_vl        <= n_vl;
            r_kl        <= n_kl;
            r_a         <= n_a;
            r_b         <= n_b;
            r_span      <= n_span;
            r_neg       <= n_neg;
            r_prod      <= n_prod;
            r_rem       <= n_rem;
            r_dcnt      <= n_dcnt;
            r_res       <= n_res;
            r_out       <= n_out;
        end
    end

endmodule

>>> bench/piecewise_linear_time_map_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_time_map_checker
// Watches the channels of the time map unit, predicts and compares results.
// ----------------------------------------------------------------------------
module piecewise_linear_time_map_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_ready,
    input  plwm_pkg::t_in_beat           i_in_beat,
    input  logic                         i_out_valid,
    input  logic                         i_out_ready,
    input  plwm_pkg::t_out_beat          i_out_beat,
    input  logic                         i_cfg_we,
    input  logic [plwm_pkg::COUNT_W-1:0] i_cfg_wdata,
    output int                           o_mismatches,
    output int                           o_outstanding
);

    localparam int TABLE_DEPTH = 64;
    localparam int TB_W        = plwm_pkg::TIME_BITS;

    logic [TB_W-1:0]              src_tbl [TABLE_DEPTH];
    logic [TB_W-1:0]              dst_tbl [TABLE_DEPTH];
    logic [plwm_pkg::COUNT_W-1:0] bp_count;
    plwm_pkg::t_out_beat          pending_results [$];
    int                           mismatch_cnt;

    assign o_mismatches  = mismatch_cnt;
    assign o_outstanding = pending_results.size();

    initial mismatch_cnt = 0;

    function automatic logic [TB_W-1:0] key_at(bit from_src, int unsigned k);
        return from_src ? src_tbl[k] : dst_tbl[k];
    endfunction

    function automatic int unsigned live_entries();
        return (bp_count > TABLE_DEPTH) ? TABLE_DEPTH : bp_count;
    endfunction

    // Index of the first key strictly above x, by the same halving search.
    function automatic int unsigned first_above(bit from_src, int unsigned n,
                                                logic [TB_W-1:0] x);
        int unsigned lo;
        int unsigned cnt;
        int unsigned step;
        lo = 0;
        cnt = n;
        while (cnt > 0) begin
            step = cnt / 2;
            if (!(x < key_at(from_src, lo + step))) begin
                lo += step + 1;
                cnt -= step + 1;
            end else begin
                cnt = step;
            end
        end
        return lo;
    endfunction

    function automatic logic [TB_W-1:0] interp_time(bit fwd, logic [TB_W-1:0] x);
        int unsigned n;
        int unsigned i;
        logic [TB_W-1:0] kl, kr, vl, vr, d, dy, q;
        logic [2*TB_W-1:0] prod;
        bit neg;
        n = live_entries();
        if (n < 2) return x;
        if (x <= key_at(fwd, 0)) return key_at(!fwd, 0);
        if (x >= key_at(fwd, n - 1)) return key_at(!fwd, n - 1);
        i = first_above(fwd, n, x);
        if (i < 1) i = 1;
        if (i > n - 1) i = n - 1;
        kl = key_at(fwd, i - 1);
        kr = key_at(fwd, i);
        vl = key_at(!fwd, i - 1);
        vr = key_at(!fwd, i);
        if (x == kl) return vl;
        if (x == kr) return vr;
        if (kr <= kl) return vl;
        if (x >= kl) begin
            d = x - kl;
            neg = 1'b0;
        end else begin
            d = kl - x;
            neg = 1'b1;
        end
        if (vr >= vl) begin
            dy = vr - vl;
        end else begin
            dy = vl - vr;
            neg = !neg;
        end
        prod = {{TB_W{1'b0}}, d} * {{TB_W{1'b0}}, dy};
        q = TB_W'(prod / {{TB_W{1'b0}}, kr - kl});
        return neg ? vl - q : vl + q;
    endfunction

    function automatic logic range_is_identity(logic [TB_W-1:0] a,
                                               logic [TB_W-1:0] b);
        int unsigned n;
        int unsigned i;
        n = live_entries();
        if (n == 0) return 1'b1;
        if (b <= a) return 1'b1;
        i = first_above(1'b1, n, a);
        if (i > 0) i--;
        while (i < n && src_tbl[i] <= b) begin
            if (dst_tbl[i] != src_tbl[i]) return 1'b0;
            i++;
        end
        return 1'b1;
    endfunction

    always @(posedge i_clk) begin
        plwm_pkg::t_out_beat want;
        plwm_pkg::t_out_beat fresh;
        plwm_pkg::t_in_beat  cmd;
        if (!i_rst_n) begin
            bp_count = '0;
            pending_results.delete();
        end else begin
            // Results first: a result never belongs to the beat taken at this edge.
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with nothing expected: mapped_time %h is_identity %b",
                           i_out_beat.mapped_time, i_out_beat.is_identity);
                    mismatch_cnt++;
                end else begin
                    want = pending_results.pop_front();
                    if (i_out_beat.mapped_time !== want.mapped_time) begin
                        $error("mapped_time: expected %h, actual %h",
                               want.mapped_time, i_out_beat.mapped_time);
                        mismatch_cnt++;
                    end
                    if (i_out_beat.is_identity !== want.is_identity) begin
                        $error("is_identity: expected %b, actual %b",
                               want.is_identity, i_out_beat.is_identity);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                cmd = i_in_beat;
                fresh = '0;
                case (plwm_pkg::t_op'(cmd.func))
                    plwm_pkg::OP_WRITE: begin
                        src_tbl[cmd.entry_index] = cmd.time_a;
                        dst_tbl[cmd.entry_index] = cmd.time_b;
                    end
                    plwm_pkg::OP_FWD: fresh.mapped_time = interp_time(1'b1, cmd.time_a);
                    plwm_pkg::OP_INV: fresh.mapped_time = interp_time(1'b0, cmd.time_a);
                    default: fresh.is_identity = range_is_identity(cmd.time_a, cmd.time_b);
                endcase
                if (plwm_pkg::t_op'(cmd.func) != plwm_pkg::OP_WRITE) begin
                    pending_results.insert(pending_results.size(), fresh);
                end
            end
            if (i_cfg_we) bp_count = i_cfg_wdata;
        end
    end

endmodule

>>> bench/piecewise_linear_time_map_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// piecewise_linear_time_map_unit_tb
// Stimulus and verdict for the piecewise-linear time map unit.
// ----------------------------------------------------------------------------
// The bench loads breakpoint tables of many sizes and shapes (rising, identity,
// nearly identity, scrambled, spanning the full time range), sets the count
// while the unit is idle and then sends forward maps, inverse maps and
// identity range queries aimed at anchors, their neighbors, the clamps and
// the segment interiors. A separate checker predicts every result and
// compares it beat by beat; this module only drives and reports.
// ----------------------------------------------------------------------------
module piecewise_linear_time_map_unit_tb;

    localparam int TABLE_DEPTH  = 64;
    localparam int RANDOM_BEATS = 1400;
    localparam int TB_W         = plwm_pkg::TIME_BITS;
    // Worst case here is a full-table walk or a long divide per beat behind a
    // long receiver stall; the limit leaves a wide margin over that.
    localparam int LIMIT_NS     = 20_000_000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_ready;
    plwm_pkg::t_in_beat           in_beat = '0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    plwm_pkg::t_out_beat          out_beat;
    logic                         cfg_we = 1'b0;
    logic [plwm_pkg::COUNT_W-1:0] cfg_wdata = '0;
    int                           mismatches;
    int                           outstanding;

    // Shadow of the table contents, used only to aim queries at anchors.
    logic [TB_W-1:0] src_shadow [TABLE_DEPTH];
    logic [TB_W-1:0] dst_shadow [TABLE_DEPTH];
    int unsigned     live_n = 0;
    int              beats_sent = 0;
    int              phases_run = 0;

    // Sender burst state.
    int burst_left = 0;
    bit gaps_on = 1'b1;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    piecewise_linear_time_map_unit DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    piecewise_linear_time_map_checker checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_ready    (in_ready),
        .i_in_beat     (in_beat),
        .i_out_valid   (out_valid),
        .i_out_ready   (out_ready),
        .i_out_beat    (out_beat),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // Receiver: the stall mode changes at random intervals, so there are
    // stretches of full throughput, stalls drawn at random each cycle and long holds.
    int ready_mode = 0;
    int mode_left = 0;
    int hold_left = 0;
    always @(negedge clk) begin
        if (mode_left == 0) begin
            ready_mode = $urandom_range(0, 2);
            mode_left = $urandom_range(100, 600);
        end else begin
            mode_left--;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (ready_mode == 0) begin
            out_ready <= 1'b1;
        end else if (ready_mode == 1) begin
            out_ready <= ($urandom_range(0, 9) < 7);
        end else begin
            if ($urandom_range(0, 15) == 0) hold_left = $urandom_range(1, 30);
            out_ready <= (hold_left == 0);
        end
    end

    // Present one beat and hold it until the unit takes it.
    task automatic send_beat(input plwm_pkg::t_in_beat b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = !gaps_on ? 0 : ($urandom_range(0, 7) == 0 ? $urandom_range(9, 25)
                                                           : $urandom_range(0, 4));
            if (gap > 0) begin
                @(negedge clk) in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_beat  <= b;
        do @(posedge clk); while (!in_ready);
        beats_sent++;
    endtask

    task automatic write_entry(input int unsigned idx, input logic [TB_W-1:0] src,
                               input logic [TB_W-1:0] dst);
        plwm_pkg::t_in_beat b;
        b.func = plwm_pkg::OP_WRITE;
        b.entry_index = plwm_pkg::IDX_W'(idx);
        b.time_a = src;
        b.time_b = dst;
        src_shadow[idx] = src;
        dst_shadow[idx] = dst;
        send_beat(b);
    endtask

    task automatic query(input plwm_pkg::t_op op, input logic [TB_W-1:0] a,
                         input logic [TB_W-1:0] b);
        plwm_pkg::t_in_beat beat;
        beat.func = op;
        beat.entry_index = plwm_pkg::IDX_W'($urandom);
        beat.time_a = a;
        beat.time_b = b;
        send_beat(beat);
    endtask

    // Drains the unit, lets trailing writes settle, then sets the count.
    task automatic set_count(input int unsigned n);
        @(negedge clk) in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= plwm_pkg::COUNT_W'(n);
        @(negedge clk) cfg_we <= 1'b0;
        live_n = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
        phases_run++;
    endtask

    // A time aimed at the interesting points of one column.
    function automatic logic [TB_W-1:0] aim_time(bit from_src);
        logic [TB_W-1:0] anchor, lo, hi;
        if (live_n == 0) return $urandom;
        anchor = from_src ? src_shadow[$urandom_range(0, live_n - 1)]
                          : dst_shadow[$urandom_range(0, live_n - 1)];
        lo = from_src ? src_shadow[0] : dst_shadow[0];
        hi = from_src ? src_shadow[live_n - 1] : dst_shadow[live_n - 1];
        case ($urandom_range(0, 9))
            0:       return anchor;
            1:       return anchor + 1;
            2:       return anchor - 1;
            3:       return '0;
            4:       return '1;
            5, 6, 7: return (hi > lo) ? lo + ($urandom % (hi - lo)) : $urandom;
            default: return $urandom;
        endcase
    endfunction

    // Loads entries 0..m-1 with one table shape.
    task automatic load_table(input int unsigned m);
        int unsigned shape;
        int unsigned max_step;
        logic [TB_W-1:0] s, d;
        shape = $urandom_range(0, 5);
        max_step = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 60_000_000;
        s = $urandom_range(0, 1 << 20);
        d = $urandom_range(0, 1 << 20);
        for (int unsigned k = 0; k < m; k++) begin
            case (shape)
                0, 1: write_entry(k, s, d);
                2:    write_entry(k, s, s);
                // Identity except for an occasional nudged output time.
                3:    write_entry(k, s, ($urandom_range(0, 7) == 0) ? s + 1 : s);
                4:    write_entry(k, $urandom, $urandom);
                default: write_entry(k, (k == m - 1) ? '1 : s, (k == 0) ? '0 : d);
            endcase
            s += $urandom_range(1, max_step);
            d += $urandom_range(1, max_step);
        end
    endtask

    initial begin : stimulus
        int unsigned n;
        int unsigned nq;
        logic [TB_W-1:0] a;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Empty table: maps pass through and the range query answers one.
        query(plwm_pkg::OP_FWD, '0, '0);
        query(plwm_pkg::OP_FWD, '1, '0);
        query(plwm_pkg::OP_INV, 32'h0001_2345, '1);
        query(plwm_pkg::OP_RANGE, '0, '1);
        query(plwm_pkg::OP_RANGE, 32'h5, 32'h5);

        // One breakpoint: still a pass-through.
        write_entry(0, 32'h0001_0000, 32'h0002_0000);
        set_count(1);
        query(plwm_pkg::OP_FWD, '0, '0);
        query(plwm_pkg::OP_INV, '1, '0);
        query(plwm_pkg::OP_RANGE, '0, 32'h0001_0000);

        // Two breakpoints across the full range: clamps, anchors, a wide divide.
        write_entry(1, '1, 32'h0003_0000);
        set_count(2);
        query(plwm_pkg::OP_FWD, '0, '0);
        query(plwm_pkg::OP_FWD, '1, '0);
        query(plwm_pkg::OP_FWD, 32'h0001_0000, '0);
        query(plwm_pkg::OP_FWD, 32'h8000_0000, '0);
        query(plwm_pkg::OP_INV, 32'h0002_8000, '0);
        query(plwm_pkg::OP_RANGE, '0, '1);
        query(plwm_pkg::OP_RANGE, 32'h10, 32'h4);

        // Falling output column between the two breakpoints.
        write_entry(1, 32'h0004_0000, 32'h0000_8000);
        query(plwm_pkg::OP_FWD, 32'h0002_0000, '0);
        query(plwm_pkg::OP_INV, 32'h0001_0000, '0);

        // Random phases: load a table, set the count, then a run of queries.
        for (int ph = 0; beats_sent < RANDOM_BEATS + 25; ph++) begin
            case (ph)
                0: n = 127;
                1: n = 64;
                2: n = 2;
                3: n = 3;
                default: begin
                    case ($urandom_range(0, 19))
                        0:             n = $urandom_range(0, 1);
                        1, 2, 3:       n = 64;
                        4, 5:          n = $urandom_range(65, 127);
                        6, 7, 8, 9, 10, 11: n = $urandom_range(9, 63);
                        default:       n = $urandom_range(2, 8);
                    endcase
                end
            endcase
            gaps_on = ($urandom_range(0, 3) != 0);
            load_table((n > TABLE_DEPTH) ? TABLE_DEPTH : n);
            set_count(n);
            nq = $urandom_range(20, 120);
            for (int unsigned j = 0; j < nq; j++) begin
                case ($urandom_range(0, 19))
                    0:          write_entry($urandom_range(0, TABLE_DEPTH - 1),
                                            $urandom, $urandom);
                    1, 2, 3, 4, 5, 6: query(plwm_pkg::OP_FWD, aim_time(1'b1), $urandom);
                    7, 8, 9, 10, 11:  query(plwm_pkg::OP_INV, aim_time(1'b0), $urandom);
                    default: begin
                        a = aim_time(1'b1);
                        if ($urandom_range(0, 4) == 0)
                            query(plwm_pkg::OP_RANGE, a, a - $urandom_range(0, 3));
                        else
                            query(plwm_pkg::OP_RANGE, a, aim_time(1'b1));
                    end
                endcase
            end
        end

        @(negedge clk) in_valid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (200) @(negedge clk);
        $display("Sent %0d beats over %0d breakpoint-count settings, counts 0 through 127.",
                 beats_sent, phases_run);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("Timed out with %0d results still expected.", outstanding);
        $display("DONE: errors detected");
        $finish;
    end

endmodule
